// ===== sv/xrpc_pkg.sv =====
`default_nettype none
package xrpc_pkg;
    localparam int VALUE_BITS = 16;
    localparam int MAX_ITEMS  = 1024;
    localparam int NODE_DEPTH = VALUE_BITS * MAX_ITEMS;
    localparam int ADDR_W     = $clog2(NODE_DEPTH + 1);
    localparam int LVL_W      = $clog2(VALUE_BITS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int TOTAL_W    = 19;
    localparam int PAIR_W     = 10;
    localparam int CFG_W      = 16;
    localparam logic [PAIR_W-1:0]  PAIR_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic CFG_RANGE_LOW  = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;
endpackage
`default_nettype wire

// ===== sv/xor_range_pair_counter.sv =====
`default_nettype none
// Counts, for each 16-bit value, the earlier values of the current set whose
// XOR with it lies in [range_low, range_high]; a frame (tlast) closes the set.
// Values sit in a binary trie held in two node memories (links and tally per
// node, registered read). Each item takes two bounded walks, each set up in
// S_SET, stepping S_QRD and S_QSTEP per trie level and closed in S_QEND, then
// an insert of S_IRD, S_ISTEP and S_IINC or S_INEW per level; the next request
// is accepted only after the result is taken, and the single port of each
// node memory sets the pace. No clearing pass: nodes are written when
// allocated and the set restarts from the root, so a new frame starts at once.
module xor_range_pair_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // item_value
    input  wire logic        s_tlast,   // last_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pairs_for_item[9:0], pair_total[28:10], pad
    output logic             m_tlast    // set_done
);
    import xrpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SET, S_QRD, S_QSTEP, S_QEND, S_RES,
        S_IRD, S_ISTEP, S_IINC, S_INEW, S_OUT
    } state_t;
    typedef logic [ADDR_W-1:0] addr_t;

    logic [2*ADDR_W-1:0]   mem_links [1:NODE_DEPTH];   // {link 1, link 0}
    logic [CNT_W-1:0]      mem_tally [1:NODE_DEPTH];
    logic [2*ADDR_W-1:0]   lnk_q;
    logic [CNT_W-1:0]      tal_q;

    state_t                state_reg;
    logic [CFG_W-1:0]      low_reg, high_reg;
    addr_t                 root_reg [2];
    addr_t                 free_reg;
    logic [CNT_W-1:0]      stored_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  last_reg;
    logic                  pass_reg;   // 0 upper walk, 1 lower walk
    logic [CFG_W-1:0]      lim_reg;
    logic [LVL_W-1:0]      lvl_reg;
    addr_t                 cur_reg;
    logic [CNT_W-1:0]      sum_reg, up_reg;
    logic                  pend_reg;   // tally read in flight
    logic [PAIR_W-1:0]     pair_reg;

    logic [BIT_W-1:0]    bi;
    logic                vb, lb;
    addr_t               rd_l0, rd_l1, ch0, ch1, chv, chn, nxt;
    logic [CFG_W-1:0]    lim_sel;
    logic                lo_empty, lim_all;
    logic [CNT_W-1:0]    cnt, sum_fin;
    logic [TOTAL_W:0]    tsum;
    logic                lnk_rd, lnk_wr, tal_rd, tal_wr;
    logic [2*ADDR_W-1:0] lnk_wdata;
    addr_t               tal_raddr, tal_waddr;
    logic [CNT_W-1:0]    tal_wdata;

    assign bi      = BIT_W'(lvl_reg - 1'b1);
    assign vb      = val_reg[bi];
    assign lb      = lim_reg[bi];
    assign rd_l0   = lnk_q[ADDR_W-1:0];
    assign rd_l1   = lnk_q[2*ADDR_W-1:ADDR_W];
    assign ch0     = (cur_reg == '0) ? root_reg[0] : rd_l0;
    assign ch1     = (cur_reg == '0) ? root_reg[1] : rd_l1;
    assign chv     = vb ? ch1 : ch0;
    assign chn     = vb ? ch0 : ch1;
    assign nxt     = lb ? chn : chv;
    assign lim_sel = pass_reg ? low_reg - 1'b1 : high_reg;
    assign lo_empty = pass_reg && (low_reg == '0);
    assign lim_all = (lim_sel >> VALUE_BITS) != '0;
    assign sum_fin = sum_reg + (pend_reg ? tal_q : '0);
    assign cnt     = (up_reg > sum_reg) ? up_reg - sum_reg : '0;
    assign tsum    = {1'b0, total_reg} + (TOTAL_W+1)'(cnt);

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {3'b0, total_reg, pair_reg};
    assign m_tlast   = last_reg;

    always_comb begin
        lnk_rd    = 1'b0;
        lnk_wr    = 1'b0;
        lnk_wdata = '0;
        tal_rd    = 1'b0;
        tal_raddr = chv;
        tal_wr    = 1'b0;
        tal_waddr = cur_reg;
        tal_wdata = tal_q + 1'b1;
        case (state_reg)
            S_QRD: begin
                if (lvl_reg == '0) begin
                    // walk survived every level: count the leaf
                    tal_rd    = 1'b1;
                    tal_raddr = cur_reg;
                end else begin
                    lnk_rd = (cur_reg != '0);
                end
            end
            S_QSTEP: tal_rd = lb && (chv != '0);
            S_IRD: lnk_rd = (cur_reg != '0);
            S_ISTEP: begin
                if (chv == '0) begin
                    if (free_reg <= addr_t'(NODE_DEPTH)) begin
                        lnk_wr    = (cur_reg != '0);
                        lnk_wdata = vb ? {free_reg, rd_l0} : {rd_l1, free_reg};
                        tal_wr    = 1'b1;
                        tal_waddr = free_reg;
                        tal_wdata = CNT_W'(1);
                    end
                end else begin
                    tal_rd = 1'b1;
                end
            end
            S_IINC: tal_wr = 1'b1;
            S_INEW: lnk_wr = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (lnk_wr) mem_links[cur_reg] <= lnk_wdata;
        if (lnk_rd) lnk_q <= mem_links[cur_reg];
        if (tal_wr) mem_tally[tal_waddr] <= tal_wdata;
        if (tal_rd) tal_q <= mem_tally[tal_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            low_reg <= '0; high_reg <= '1;
            root_reg[0] <= '0; root_reg[1] <= '0;
            free_reg <= addr_t'(1);
            stored_reg <= '0; total_reg <= '0;
            val_reg <= '0; last_reg <= 1'b0; pass_reg <= 1'b0;
            lim_reg <= '0; lvl_reg <= '0; cur_reg <= '0;
            sum_reg <= '0; up_reg <= '0; pend_reg <= 1'b0;
            pair_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        if (cfg_index == CFG_RANGE_LOW) low_reg <= cfg_data;
                        else high_reg <= cfg_data;
                    end
                    if (s_tvalid) begin
                        val_reg <= s_tdata[VALUE_BITS-1:0];
                        last_reg <= s_tlast;
                        pass_reg <= 1'b0;
                        state_reg <= S_SET;
                    end
                end
                S_SET: begin
                    lim_reg <= lim_sel;
                    lvl_reg <= LVL_W'(VALUE_BITS);
                    cur_reg <= '0;
                    pend_reg <= 1'b0;
                    // a bound above the value width counts every stored value
                    sum_reg <= (!lo_empty && lim_all) ? stored_reg : '0;
                    if (lo_empty) state_reg <= S_RES;
                    else if (lim_all) state_reg <= S_QEND;
                    else state_reg <= S_QRD;
                end
                S_QRD: begin
                    sum_reg <= sum_fin;
                    pend_reg <= (lvl_reg == '0);
                    state_reg <= (lvl_reg == '0) ? S_QEND : S_QSTEP;
                end
                S_QSTEP: begin
                    pend_reg <= lb && (chv != '0);
                    cur_reg <= nxt;
                    lvl_reg <= lvl_reg - 1'b1;
                    state_reg <= (nxt == '0) ? S_QEND : S_QRD;
                end
                S_QEND: begin
                    pend_reg <= 1'b0;
                    if (!pass_reg) begin
                        up_reg <= sum_fin;
                        pass_reg <= 1'b1;
                        state_reg <= S_SET;
                    end else begin
                        sum_reg <= sum_fin;
                        state_reg <= S_RES;
                    end
                end
                S_RES: begin
                    pair_reg <= (cnt > CNT_W'(PAIR_MAX)) ? PAIR_MAX : PAIR_W'(cnt);
                    total_reg <= tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
                    lvl_reg <= LVL_W'(VALUE_BITS);
                    cur_reg <= '0;
                    if (stored_reg < CNT_W'(MAX_ITEMS)) begin
                        stored_reg <= stored_reg + 1'b1;
                        state_reg <= S_IRD;
                    end else begin
                        // store full: queried only
                        state_reg <= S_OUT;
                    end
                end
                S_IRD: state_reg <= S_ISTEP;
                S_ISTEP: begin
                    if (chv == '0) begin
                        if (free_reg > addr_t'(NODE_DEPTH)) begin
                            state_reg <= S_OUT;
                        end else begin
                            if (cur_reg == '0) root_reg[vb] <= free_reg;
                            cur_reg <= free_reg;
                            free_reg <= free_reg + 1'b1;
                            state_reg <= S_INEW;
                        end
                    end else begin
                        cur_reg <= chv;
                        state_reg <= S_IINC;
                    end
                end
                S_IINC, S_INEW: begin
                    lvl_reg <= lvl_reg - 1'b1;
                    state_reg <= (lvl_reg == LVL_W'(1)) ? S_OUT : S_IRD;
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                        if (last_reg) begin
                            root_reg[0] <= '0; root_reg[1] <= '0;
                            free_reg <= addr_t'(1);
                            stored_reg <= '0; total_reg <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
